FILE: hw/rtl/mtpd_pkg.sv
// ----------------------------------------------------------------------------
// mtpd_pkg
// Shared widths, register map and the decision record of the detector.
// ----------------------------------------------------------------------------
package mtpd_pkg;

    localparam int WINDOW_LEN_DEF = 16;

    // Q12.4 sample and height width
    localparam int DATA_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MIN_DISTANCE = 1'b0;  // word index of min_distance

    // stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // verdict for one sample
    typedef struct packed {
        logic              turn;
        logic [DATA_W-1:0] gap;
    } mtpd_decision_t;

endpackage

FILE: hw/rtl/motion_turning_point_detector.sv
// ----------------------------------------------------------------------------
// motion_turning_point_detector
// Finds turning points in a stream of vertical motion samples.
//
//   channel   dir  payload                                      handshake
//   s_axis    in   tdata: delta_y, tip_y                        tvalid/tready
//   m_axis    out  tdata: turn_found, seek_inverted, height_gap tvalid/tready
//   apb       in   min_distance at byte address 0               psel/penable
//
// One result per sample, one sample per cycle sustained unless m_tready
// stalls the result register. Path: input register, then decision and
// state update into the result register. The state update on one sample
// is ready for the next in the following cycle. Reset is synchronous and
// clears window, sums, last height, direction and min_distance. A stalled
// result holds; the input register still takes a sample as the result drains.
// ----------------------------------------------------------------------------
module motion_turning_point_detector
    import mtpd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] delta_y, [31:16] tip_y

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] turn_found, [1] seek_inverted,
                                             // [17:2] height_gap, [23:18] zero

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SUM_W = DATA_W + $clog2(WINDOW_LEN);

    logic                     in_valid_reg;
    logic signed [DATA_W-1:0] dy_reg;
    logic signed [DATA_W-1:0] tip_reg;

    logic                     out_valid_reg;
    logic                     out_turn_reg;
    logic                     out_inv_reg;
    logic [DATA_W-1:0]        out_gap_reg;

    logic signed [DATA_W-1:0] last_height_reg;
    logic                     dir_neg_reg;
    logic [DATA_W-1:0]        min_distance_reg;

    logic                     advance;
    logic signed [SUM_W-1:0]  older_next;
    logic signed [SUM_W-1:0]  newer_next;
    mtpd_decision_t           decision;
    logic                     cfg_write;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1] == REG_MIN_DISTANCE);
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_MIN_DISTANCE)
                     ? APB_DATA_W'(min_distance_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_distance_reg <= '0;
        end else if (cfg_write) begin
            min_distance_reg <= pwdata[DATA_W-1:0];
        end
    end

    // input register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            dy_reg  <= s_tdata[DATA_W-1:0];
            tip_reg <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    mtpd_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (advance),
        .delta_y    (dy_reg),
        .older_next (older_next),
        .newer_next (newer_next)
    );

    mtpd_decide #(
        .SUM_W        (SUM_W)
    ) u_decide (
        .older_sum    (older_next),
        .newer_sum    (newer_next),
        .tip_y        (tip_reg),
        .last_height  (last_height_reg),
        .dir_negative (dir_neg_reg),
        .min_distance (min_distance_reg),
        .decision     (decision)
    );

    // detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_height_reg <= '0;
            dir_neg_reg     <= 1'b0;
        end else if (advance && decision.turn) begin
            last_height_reg <= tip_reg;
            dir_neg_reg     <= !dir_neg_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_turn_reg <= decision.turn;
            out_inv_reg  <= dir_neg_reg ^ decision.turn;
            out_gap_reg  <= decision.gap;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - DATA_W - 2)'(0), out_gap_reg, out_inv_reg, out_turn_reg};

endmodule

FILE: hw/rtl/mtpd_window.sv
// ----------------------------------------------------------------------------
// mtpd_window
// Shift line of the last WINDOW_LEN displacements with running sums of
// the older and the newer half. The sums after the pending push are
// presented combinationally and taken into the registers on push.
// ----------------------------------------------------------------------------
module mtpd_window
    import mtpd_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int SUM_W      = DATA_W + $clog2(WINDOW_LEN)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic signed [DATA_W-1:0] delta_y,
    output logic signed [SUM_W-1:0]  older_next,
    output logic signed [SUM_W-1:0]  newer_next
);

    localparam int HALF = WINDOW_LEN / 2;

    logic signed [DATA_W-1:0] win_reg [WINDOW_LEN];
    logic signed [SUM_W-1:0]  older_reg;
    logic signed [SUM_W-1:0]  newer_reg;

    // oldest entry drops out of the older half, the entry at HALF crosses over
    assign older_next = older_reg - SUM_W'(win_reg[0]) + SUM_W'(win_reg[HALF]);
    assign newer_next = newer_reg - SUM_W'(win_reg[HALF]) + SUM_W'(delta_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
            older_reg <= '0;
            newer_reg <= '0;
        end else if (push) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW_LEN-1] <= delta_y;
            older_reg             <= older_next;
            newer_reg             <= newer_next;
        end
    end

endmodule

FILE: hw/rtl/mtpd_decide.sv
// ----------------------------------------------------------------------------
// mtpd_decide
// Turning point test: signed half sums against the current direction and
// height distance from the last turning point.
// ----------------------------------------------------------------------------
module mtpd_decide
    import mtpd_pkg::*;
#(
    parameter int SUM_W = DATA_W + $clog2(WINDOW_LEN_DEF)
) (
    input  logic signed [SUM_W-1:0]  older_sum,
    input  logic signed [SUM_W-1:0]  newer_sum,
    input  logic signed [DATA_W-1:0] tip_y,
    input  logic signed [DATA_W-1:0] last_height,
    input  logic                     dir_negative,
    input  logic        [DATA_W-1:0] min_distance,
    output mtpd_decision_t           decision
);

    logic signed [DATA_W:0] diff;
    logic        [DATA_W:0] diff_neg;
    logic        [DATA_W-1:0] gap;
    logic                   sums_ok;

    assign diff     = {tip_y[DATA_W-1], tip_y} - {last_height[DATA_W-1], last_height};
    assign diff_neg = -diff;
    assign gap      = diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];

    // negative direction: -older >= 0 and -newer < 0, compared without negating
    always_comb begin
        if (dir_negative) begin
            sums_ok = (older_sum <= 0) && (newer_sum > 0);
        end else begin
            sums_ok = (older_sum >= 0) && (newer_sum < 0);
        end
    end

    assign decision.turn = sums_ok && (gap >= min_distance);
    assign decision.gap  = gap;

endmodule

FILE: test/motion_turning_point_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_turning_point_detector_tb
// Drives displacement/height samples into the detector and checks every
// result against a typed verdict or a cycle-free model of the sliding window,
// the signed half sums, the direction flip and the min_distance gate. A short
// directed table comes first, then swinging motion strokes mixed with noise
// under several min_distance settings, random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module motion_turning_point_detector_tb
    import mtpd_pkg::*;
();

    localparam int WIN_LEN = WINDOW_LEN_DEF;
    localparam int SUM_W = DATA_W + $clog2(WIN_LEN) + 1;
    localparam int PHASE_ITEMS = 184;
    localparam logic [APB_ADDR_W-1:0] MIN_DIST_ADDR = {REG_MIN_DISTANCE, 2'b00};

    typedef struct packed {
        logic              turn;
        logic              seek_inv;
        logic [DATA_W-1:0] gap;
    } turn_verdict_t;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    // for ROW_CFG rows dy carries the min_distance value
    typedef struct {
        row_kind_t     kind;
        logic [15:0]   dy;
        logic [15:0]   tip;
        bit            typed;
        turn_verdict_t want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [15:0] delta_y, [31:16] tip_y
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [0] turn_found, [1] seek_inverted,
                                      // [17:2] height_gap, [23:18] zero
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    logic signed [15:0] win_hist [WIN_LEN];
    logic               seek_neg;
    logic signed [15:0] turn_height;
    logic [15:0]        min_gap_cfg;

    turn_verdict_t verdict_q[$];
    int            err_count    = 0;
    int            samples_sent = 0;
    int            results_seen = 0;
    int            turns_seen   = 0;
    int            cfg_writes   = 0;
    bit            tx_idle      = 1'b1;
    bit            rx_idle      = 1'b1;
    int            rx_hold_req  = 0;

    motion_turning_point_detector #(.WINDOW_LEN(WIN_LEN)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("ERROR: run did not complete within the time limit");
        $display("** motion_turning_point_detector: FAILED **");
        $finish;
    end

    task automatic note_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, what);
    endtask

    // append one stimulus row at the tail of the table
    task automatic add_row(ref stim_row_t tbl[$], input stim_row_t r);
        tbl.insert(tbl.size(), r);
    endtask

    // shift in one sample, gate on the signed half sums and the height gap
    function automatic turn_verdict_t predict_turn(input logic signed [15:0] dy,
                                                   input logic signed [15:0] tip);
        logic signed [SUM_W-1:0] older_acc;
        logic signed [SUM_W-1:0] newer_acc;
        logic signed [16:0]      tip_diff;
        logic [16:0]             tip_dist;
        turn_verdict_t           v;
        older_acc = '0;
        newer_acc = '0;
        for (int i = 0; i < WIN_LEN - 1; i++)
            win_hist[i] = win_hist[i + 1];
        win_hist[WIN_LEN - 1] = dy;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (i < WIN_LEN / 2)
                older_acc = older_acc + win_hist[i];
            else
                newer_acc = newer_acc + win_hist[i];
        end
        if (seek_neg) begin
            older_acc = -older_acc;
            newer_acc = -newer_acc;
        end
        tip_diff = {tip[15], tip} - {turn_height[15], turn_height};
        tip_dist = tip_diff[16] ? -tip_diff : tip_diff;
        v.gap = tip_dist[15:0];
        v.turn = !older_acc[SUM_W-1] && newer_acc[SUM_W-1] && (v.gap >= min_gap_cfg);
        if (v.turn) begin
            turn_height = tip;
            seek_neg = !seek_neg;
        end
        v.seek_inv = seek_neg;
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer_sample(input logic [15:0] dy, input logic [15:0] tip,
                                input bit typed = 1'b0, input turn_verdict_t want = '0);
        int unsigned   gap_cycles;
        turn_verdict_t calc;
        gap_cycles = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap_cycles != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tip, dy};
        do @(posedge aclk); while (!s_tready);
        calc = predict_turn(dy, tip);
        verdict_q.insert(verdict_q.size(), typed ? want : calc);
        samples_sent++;
        @(negedge aclk);
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [15:0] val,
                              output logic [APB_DATA_W-1:0] rd);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MIN_DIST_ADDR;
        pwdata  <= APB_DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_min_gap(input logic [15:0] val);
        logic [APB_DATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, val, rd);
        min_gap_cfg = val;
        cfg_writes++;
        apb_access(1'b0, '0, rd);
        if (rd[15:0] !== val)
            note_mismatch($sformatf("min_distance read back %h, wrote %h", rd[15:0], val));
    endtask

    // result sink: per-result stall, optional long hold-off, check on transfer
    initial begin : result_sink
        int unsigned   stall;
        int            hold;
        turn_verdict_t got;
        turn_verdict_t want;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_req != 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            stall = rx_idle ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.turn     = m_tdata[0];
            got.seek_inv = m_tdata[1];
            got.gap      = m_tdata[17:2];
            if (m_tdata[M_TDATA_W-1:18] !== '0)
                note_mismatch($sformatf("pad bits not zero: %h", m_tdata));
            if (verdict_q.size() == 0) begin
                note_mismatch("result with nothing outstanding");
            end else begin
                want = verdict_q[0];
                verdict_q.delete(0);
                if (got.turn !== want.turn)
                    note_mismatch($sformatf("turn_found %b, want %b", got.turn, want.turn));
                if (got.seek_inv !== want.seek_inv)
                    note_mismatch($sformatf("seek_inverted %b, want %b",
                                            got.seek_inv, want.seek_inv));
                if (got.gap !== want.gap)
                    note_mismatch($sformatf("height_gap %h, want %h", got.gap, want.gap));
            end
            if (got.turn === 1'b1)
                turns_seen++;
            results_seen++;
        end
    end

    initial begin : stimulus
        stim_row_t             rows[$];
        logic [APB_DATA_W-1:0] rd;
        logic signed [15:0]    tip_track;
        logic [15:0]           dy;
        bit                    heading_up;
        int unsigned           mag;
        int unsigned           amp;
        int unsigned           run_len;
        int                    phase_end;
        logic [15:0]           gap_setting;
        bit                    hold_done;
        bit                    drain_done;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        foreach (win_hist[i]) win_hist[i] = '0;
        seek_neg    = 1'b0;
        turn_height = '0;
        min_gap_cfg = '0;
        tip_track   = '0;
        heading_up  = 1'b1;
        hold_done   = 1'b0;
        drain_done  = 1'b0;

        // a negative first step turns at once; the next row hits the widest gap
        add_row(rows, '{ROW_SAMPLE, 16'hFFFF, 16'h7FFF, 1'b1, '{1'b1, 1'b1, 16'd32767}});
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h8000, 1'b1, '{1'b0, 1'b1, 16'hFFFF}});
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b1, '{1'b0, 1'b1, 16'd32767}});
        // negative direction: a rising newer half now counts as the turn
        add_row(rows, '{ROW_SAMPLE, 16'h7FFF, 16'd100,  1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h7FFF, 16'd200,  1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h8000, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h8000, 16'h8000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h8000, 16'h7FFF, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h8000, 16'hFFFF, 1'b0, '0});
        // zero sums are not negative
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_CFG,    16'hFFFF, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h8000, 16'h8000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h8000, 16'h7FFF, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h7FFF, 16'h8000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b0, '0});
        add_row(rows, '{ROW_CFG,    16'h0001, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h0000, 16'h0000, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'hFFFF, 16'h0001, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h0001, 16'hFFFF, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'h5555, 16'hAAAA, 1'b0, '0});
        add_row(rows, '{ROW_SAMPLE, 16'hAAAA, 16'h5555, 1'b0, '0});

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_access(1'b0, '0, rd);
        if (rd[15:0] !== 16'h0000)
            note_mismatch($sformatf("min_distance after reset %h, want 0000", rd[15:0]));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                set_min_gap(rows[i].dy);
            else
                offer_sample(rows[i].dy, rows[i].tip, rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: gap_setting = 16'h0000;
                1: gap_setting = 16'hFFFF;
                2: gap_setting = 16'($urandom_range(0, 64));
                3: gap_setting = 16'($urandom_range(32, 1024));
                4: gap_setting = 16'($urandom);
                default: gap_setting = 16'($urandom_range(1, 16));
            endcase
            set_min_gap(gap_setting);
            tx_idle = (ph != 3) && (ph != 4);
            rx_idle = (ph != 3) && (ph != 5);
            phase_end = samples_sent + PHASE_ITEMS;
            while (samples_sent < phase_end) begin
                // hold the sink off while the source keeps pushing
                if (ph == 3 && !hold_done && samples_sent >= phase_end - 120) begin
                    rx_hold_req = 80;
                    hold_done   = 1'b1;
                end
                // let everything come out before going on
                if (ph == 1 && !drain_done && samples_sent >= phase_end - 90) begin
                    drain_results();
                    drain_done = 1'b1;
                end
                if ($urandom_range(0, 9) < 2) begin
                    repeat ($urandom_range(1, 6)) offer_sample(16'($urandom), 16'($urandom));
                end else begin
                    run_len = $urandom_range(1, 20);
                    amp = ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(1, 400);
                    repeat (run_len) begin
                        mag = $urandom_range(0, amp);
                        dy = heading_up ? 16'(mag) : 16'(-mag);
                        tip_track = tip_track + $signed(dy);
                        offer_sample(dy, tip_track);
                    end
                    heading_up = !heading_up;
                end
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (verdict_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        $display("Run covered %0d samples, %0d results, %0d turning points, %0d register writes,",
                 samples_sent, results_seen, turns_seen, cfg_writes);
        $display("with swinging strokes and noise under source gaps, sink stalls and a hold-off.");
        if (err_count == 0) begin
            $display("** motion_turning_point_detector: PASSED **");
        end else begin
            $display("%0d mismatches", err_count);
            $display("** motion_turning_point_detector: FAILED **");
        end
        $finish;
    end

endmodule
